@@ design/bmq_pkg.sv @@
// bmq_pkg: shared types and constants of the bounded message queue
// no dependencies; imported by the interfaces and every design module
package bmq_pkg;

  // fixed field widths of the item channels
  localparam int OP_W   = 3;
  localparam int DATA_W = 64;
  localparam int LEN_W  = 4;
  localparam int CNT_W  = 5;
  localparam int ST_W   = 2;

  // configuration port widths
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // register index codes (word index taken from paddr[2])
  localparam logic REG_MAX_ENTRIES = 1'b0;

  // reset value of the message limit
  localparam logic [CNT_W-1:0] MAX_ENTRIES_RESET = 5'd16;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
  localparam logic [OP_W-1:0] OP_UNDO    = 3'd1;
  localparam logic [OP_W-1:0] OP_DEQUEUE = 3'd2;
  localparam logic [OP_W-1:0] OP_PEEK    = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  // one stored message
  typedef struct packed {
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] data;
  } msg_t;

  // one result item held in the output register
  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  length;
    logic [CNT_W-1:0]  count;
  } res_t;

  // keep the low n bytes of a message word, clear the rest
  function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int b = 0; b < DATA_W / 8; b++) begin
      m[8*b +: 8] = (n > LEN_W'(b)) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

@@ design/bmq_if.sv @@
// bmq_if: valid/ready channel interfaces for operation items and result items
// depends on bmq_pkg for the field widths
interface bmq_in_if;
  import bmq_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [DATA_W-1:0] msg_data;
  logic [LEN_W-1:0]  msg_length;

  modport source (output valid, output opcode, output msg_data, output msg_length,
                  input ready);
  modport sink   (input valid, input opcode, input msg_data, input msg_length,
                  output ready);
endinterface

interface bmq_out_if;
  import bmq_pkg::*;

  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [DATA_W-1:0] out_data;
  logic [LEN_W-1:0]  out_length;
  logic [CNT_W-1:0]  entry_count;
  logic              is_empty;

  modport source (output valid, output status, output out_data, output out_length,
                  output entry_count, output is_empty, input ready);
  modport sink   (input valid, input status, input out_data, input out_length,
                  input entry_count, input is_empty, output ready);
endinterface

@@ design/bounded_message_queue.sv @@
// bounded_message_queue: bounded message FIFO with undo, dequeue, peek and clear
// push, undo, clear and empty-queue ops give their result in the cycle after accept;
// dequeue and peek on a non-empty queue go through the memory read and S_READ first
// throughput: one item per cycle while out_if takes results; no new item during a read
// reset (sync, rst_n low): queue empty, pointers zero, limit 16, no result pending
module bounded_message_queue #(
  parameter int DEPTH     = 16,
  parameter int MSG_BYTES = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bmq_in_if.sink                         in_if,
  bmq_out_if.source                      out_if,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [bmq_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [bmq_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [bmq_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import bmq_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MSG_BYTES);

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t           state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  res_t             res_r, res_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic [CNT_W-1:0] max_entries;
  logic             in_fire;
  logic             full;
  logic             empty;
  logic [LEN_W-1:0] len_sat;
  logic [PTR_W-1:0] tail_next_slot, tail_prev_slot, head_next_slot;

  logic             wr_en;
  msg_t             wr_msg;
  logic             rd_en;
  logic [PTR_W-1:0] rd_addr;
  msg_t             rd_msg;

  // configuration registers
  bmq_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (cfg_psel),
    .penable     (cfg_penable),
    .pwrite      (cfg_pwrite),
    .paddr       (cfg_paddr),
    .pwdata      (cfg_pwdata),
    .prdata      (cfg_prdata),
    .pready      (cfg_pready),
    .max_entries (max_entries)
  );

  // message store; the queue only reads or writes it in a given cycle, and a read
  // issued right after a push sees the written entry, as the write lands first
  bmq_mem #(
    .DEPTH (DEPTH),
    .PTR_W (PTR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_r),
    .wr_msg  (wr_msg),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_msg  (rd_msg)
  );

  // handshake
  assign in_if.ready = (state_r == S_IDLE) && (!out_valid_r || out_if.ready);
  assign in_fire     = in_if.valid && in_if.ready;

  // occupancy; limit is the smaller of the register and the store depth
  assign empty = (count_r == '0);
  assign full  = (count_r >= max_entries) || (32'(count_r) >= DEPTH);

  // ring pointer neighbors
  assign tail_next_slot = (tail_r == LAST_SLOT) ? '0 : tail_r + 1'b1;
  assign tail_prev_slot = (tail_r == '0) ? LAST_SLOT : tail_r - 1'b1;
  assign head_next_slot = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;

  // pushed message: length saturated, bytes past it cleared
  assign len_sat        = (in_if.msg_length > LEN_MAX) ? LEN_MAX : in_if.msg_length;
  assign wr_msg.length  = len_sat;
  assign wr_msg.data    = in_if.msg_data & byte_mask(len_sat);

  // operation decode and next state
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    res_nxt       = res_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = head_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_nxt.status = ST_OK;
          res_nxt.data   = '0;
          res_nxt.length = '0;
          out_valid_nxt  = 1'b1;
          unique case (in_if.opcode)
            OP_PUSH: begin
              if (full) begin
                res_nxt.status = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                tail_nxt  = tail_next_slot;
                count_nxt = count_r + 1'b1;
              end
            end
            OP_UNDO: begin
              if (empty) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                tail_nxt  = tail_prev_slot;
                count_nxt = count_r - 1'b1;
              end
            end
            OP_DEQUEUE: begin
              if (empty) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                rd_en         = 1'b1;
                rd_addr       = head_r;
                head_nxt      = head_next_slot;
                count_nxt     = count_r - 1'b1;
                out_valid_nxt = 1'b0;
                state_nxt     = S_READ;
              end
            end
            OP_PEEK: begin
              if (empty) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                rd_en         = 1'b1;
                rd_addr       = tail_prev_slot;
                out_valid_nxt = 1'b0;
                state_nxt     = S_READ;
              end
            end
            OP_CLEAR: begin
              head_nxt  = '0;
              tail_nxt  = '0;
              count_nxt = '0;
            end
            default: begin
            end
          endcase
          res_nxt.count = count_nxt;
        end
      end
      S_READ: begin
        // read data is back, output register is free here
        res_nxt.data   = rd_msg.data;
        res_nxt.length = rd_msg.length;
        out_valid_nxt  = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state, pointers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
    end
    res_r <= res_nxt;
  end

  // result channel
  assign out_if.valid       = out_valid_r;
  assign out_if.status      = res_r.status;
  assign out_if.out_data    = res_r.data;
  assign out_if.out_length  = res_r.length;
  assign out_if.entry_count = res_r.count;
  assign out_if.is_empty    = (res_r.count == '0);

`ifndef SYNTHESIS
  // a read in flight never finds a result still waiting
  a_read_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> !out_valid_r)
    else $error("result pending while memory read in flight");

  // occupancy stays within the store
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= DEPTH)
    else $error("held count beyond store depth");

  // clear empties the queue and rewinds both pointers
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_if.opcode == OP_CLEAR)) |=>
      ((count_r == '0) && (head_r == '0) && (tail_r == '0)))
    else $error("clear left queue non-empty");

  // a dropped push leaves the queue untouched
  a_full_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_if.opcode == OP_PUSH) && full) |=>
      ($stable(count_r) && $stable(tail_r) && (res_r.status == ST_FULL)))
    else $error("full push changed queue state");

  // a memory write and a memory read never share a cycle
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en))
    else $error("store read and written in one cycle");
`endif

endmodule

@@ design/bmq_regs.sv @@
// bmq_regs: APB-style configuration register block (message limit)
// depends on bmq_pkg
module bmq_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bmq_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bmq_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bmq_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic [bmq_pkg::CNT_W-1:0]      max_entries
);
  import bmq_pkg::*;

  logic [CNT_W-1:0] max_entries_r;
  logic             wr_hit;

  // zero wait states
  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && pready &&
                  (paddr[CFG_ADDR_W-1] == REG_MAX_ENTRIES);

  // limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= MAX_ENTRIES_RESET;
    end else if (wr_hit) begin
      max_entries_r <= pwdata[CNT_W-1:0];
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (paddr[CFG_ADDR_W-1] == REG_MAX_ENTRIES) begin
      prdata = CFG_DATA_W'(max_entries_r);
    end
  end

  assign max_entries = max_entries_r;

endmodule

@@ design/bmq_mem.sv @@
// bmq_mem: message store, one write port and one read port with registered read data
// depends on bmq_pkg for the message type
module bmq_mem #(
  parameter int DEPTH = 16,
  parameter int PTR_W = 4
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [PTR_W-1:0]    wr_addr,
  input  bmq_pkg::msg_t       wr_msg,
  input  logic                rd_en,
  input  logic [PTR_W-1:0]    rd_addr,
  output bmq_pkg::msg_t       rd_msg
);
  import bmq_pkg::*;

  msg_t mem_r [DEPTH];
  msg_t rd_msg_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_msg;
    end
  end

  // read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_msg_r <= mem_r[rd_addr];
    end
  end

  assign rd_msg = rd_msg_r;

endmodule
